/* sv/key_press_duration_classifier_macros.svh */
// Assertion helpers used by the classifier RTL.
`ifndef KEY_PRESS_DURATION_CLASSIFIER_MACROS_SVH
`define KEY_PRESS_DURATION_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kpdc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KPDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kpdc: next-cycle check failed");

`endif

/* sv/kpdc_pkg.sv */
package kpdc_pkg;

    localparam int unsigned TimeW = 16;
    localparam int unsigned CfgIdxW = 3;

    typedef logic [TimeW-1:0] time_t;

    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TIME      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_LONG_TIME          = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_LONG_REPEAT        = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_VERY_LONG_TIME     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_VERY_LONG_REPEAT   = 3'd4;

    localparam time_t DEBOUNCE_TIME_RST    = 16'd10;
    localparam time_t LONG_TIME_RST        = 16'd500;
    localparam time_t LONG_REPEAT_RST      = 16'd80;
    localparam time_t VERY_LONG_TIME_RST   = 16'd2000;
    localparam time_t VERY_LONG_REPEAT_RST = 16'd12;

    typedef enum logic [3:0] {
        EV_NONE             = 4'd0,
        EV_START_SHORT      = 4'd1,
        EV_START_LONG       = 4'd2,
        EV_START_VERY_LONG  = 4'd3,
        EV_LONG_REPEAT      = 4'd4,
        EV_VERY_LONG_REPEAT = 4'd5,
        EV_END_SHORT        = 4'd6,
        EV_END_LONG         = 4'd7,
        EV_END_VERY_LONG    = 4'd8
    } event_t;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_SHORT     = 4'b0010,
        ST_LONG      = 4'b0100,
        ST_VERY_LONG = 4'b1000
    } press_state_t;

    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [TimeW:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
        end
    endfunction

endpackage

/* sv/key_press_duration_classifier.sv */
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_pressed, s_elapsed_ms
// m_        m_valid / m_ready    m_event_res
// cfg_      cfg_wr_en            cfg_index, cfg_wdata
//
// The press state and both timers update at acceptance.
// The result appears in the output register the cycle after acceptance.
// A new request is accepted every cycle while the output register is empty or being drained.
// Reset is synchronous on aresetn low and restores the default timing registers.
`include "key_press_duration_classifier_macros.svh"

module key_press_duration_classifier
    import kpdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_pressed,
    input  logic [15:0]        s_elapsed_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_event_res,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [TimeW-1:0]   cfg_wdata
);

    time_t debounce_time_reg;
    time_t long_time_reg;
    time_t long_repeat_reg;
    time_t very_long_time_reg;
    time_t very_long_repeat_reg;

    press_state_t state_reg, state_next;
    time_t        phase_reg, phase_next;
    time_t        repeat_reg, repeat_next;
    event_t       event_next;
    logic [3:0]   m_event_res_reg;
    logic         m_valid_reg;

    time_t phase_sum;
    time_t repeat_sum;
    logic  accept;

    assign s_ready     = !m_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_event_res = m_event_res_reg;

    assign phase_sum  = sat_add(phase_reg, s_elapsed_ms);
    assign repeat_sum = sat_add(repeat_reg, s_elapsed_ms);

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        repeat_next = repeat_reg;
        event_next  = EV_NONE;
        if (s_pressed) begin
            phase_next = phase_sum;
            unique case (state_reg)
                ST_IDLE: begin
                    repeat_next = '0;
                    if (phase_sum >= debounce_time_reg) begin
                        state_next = ST_SHORT;
                        phase_next = '0;
                        event_next = EV_START_SHORT;
                    end
                end
                ST_SHORT: begin
                    repeat_next = '0;
                    if (phase_sum >= long_time_reg) begin
                        state_next = ST_LONG;
                        phase_next = '0;
                        event_next = EV_START_LONG;
                    end
                end
                ST_LONG: begin
                    repeat_next = repeat_sum;
                    if (phase_sum >= very_long_time_reg) begin
                        state_next = ST_VERY_LONG;
                        phase_next = '0;
                        event_next = EV_START_VERY_LONG;
                    end else if (repeat_sum >= long_repeat_reg) begin
                        repeat_next = repeat_sum - long_repeat_reg;
                        event_next  = EV_LONG_REPEAT;
                    end
                end
                ST_VERY_LONG: begin
                    if (phase_sum >= very_long_repeat_reg) begin
                        phase_next = '0;
                        event_next = EV_VERY_LONG_REPEAT;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end else begin
            state_next  = ST_IDLE;
            phase_next  = '0;
            repeat_next = '0;
            unique case (state_reg)
                ST_SHORT:     event_next = EV_END_SHORT;
                ST_LONG:      event_next = EV_END_LONG;
                ST_VERY_LONG: event_next = EV_END_VERY_LONG;
                default:      event_next = EV_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg    <= DEBOUNCE_TIME_RST;
            long_time_reg        <= LONG_TIME_RST;
            long_repeat_reg      <= LONG_REPEAT_RST;
            very_long_time_reg   <= VERY_LONG_TIME_RST;
            very_long_repeat_reg <= VERY_LONG_REPEAT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE_TIME:    debounce_time_reg    <= cfg_wdata;
                CFG_LONG_TIME:        long_time_reg        <= cfg_wdata;
                CFG_LONG_REPEAT:      long_repeat_reg      <= cfg_wdata;
                CFG_VERY_LONG_TIME:   very_long_time_reg   <= cfg_wdata;
                CFG_VERY_LONG_REPEAT: very_long_repeat_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            repeat_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                phase_reg   <= phase_next;
                repeat_reg  <= repeat_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_event_res_reg <= event_next;
        end
    end

    // The repeat accumulator only runs in the long state; it holds in the very long state.
    `KPDC_ASSERT_SAME(a_repeat_clear, aclk, aresetn, (state_reg == ST_IDLE || state_reg == ST_SHORT), (repeat_reg == '0))
    // An empty output register never blocks the input side.
    `KPDC_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_ready)
    // A released key always returns the classifier to idle.
    `KPDC_ASSERT_NEXT(a_release_idle, aclk, aresetn, (accept && !s_pressed), (state_reg == ST_IDLE && phase_reg == '0))
    // From idle the only possible results are none or the start of a short press.
    `KPDC_ASSERT_NEXT(a_idle_events, aclk, aresetn, (accept && state_reg == ST_IDLE), (m_event_res_reg == EV_NONE || m_event_res_reg == EV_START_SHORT))

endmodule
